FILE: design/esr_pkg.sv
// Shared types and constants for the square-root envelope segment.
package esr_pkg;

    // Fraction and root are Q1.16 (one integer bit so 1.0 is exact).
    localparam int FRAC_BITS = 16;
    localparam int ROOT_BITS = FRAC_BITS + 1;
    localparam int QUOT_BITS = FRAC_BITS + 1;
    localparam int SQRT_VAL_W = 2 * ROOT_BITS;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        REQ_START = 2'd0,
        REQ_TICK  = 2'd1,
        REQ_STOP  = 2'd2
    } t_req;

    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END    = 2'd2;

    // Control into and status out of the serial arithmetic units.
    typedef struct packed {
        logic start;
    } t_unit_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

endpackage

FILE: design/esr_div.sv
// Bit-serial restoring divider producing the Q1.16 ratio elapsed/length.
module esr_div #(
    parameter int NUM_BITS = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  esr_pkg::t_unit_ctl           i_ctl,
    input  logic [NUM_BITS-1:0]          i_dividend,
    input  logic [NUM_BITS-1:0]          i_divisor,
    output esr_pkg::t_unit_sts           o_sts,
    output logic [esr_pkg::QUOT_BITS-1:0] o_quot
);

    localparam int CNT_W = $clog2(esr_pkg::QUOT_BITS);

    logic                          r_busy, n_busy;
    logic                          r_done, n_done;
    logic [CNT_W-1:0]              r_cnt, n_cnt;
    logic [NUM_BITS:0]             r_rem, n_rem;
    logic [esr_pkg::QUOT_BITS-1:0] r_quot, n_quot;
    logic [NUM_BITS:0]             diff;
    logic                          q_bit;

    // Dividend <= divisor, so one unshifted step then one bit per shift.
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quot = r_quot;
        q_bit  = (r_rem >= {1'b0, i_divisor});
        diff   = q_bit ? (r_rem - {1'b0, i_divisor}) : r_rem;
        if (i_ctl.start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(esr_pkg::QUOT_BITS - 1);
            n_rem  = {1'b0, i_dividend};
            n_quot = '0;
        end else if (r_busy) begin
            n_rem  = {diff[NUM_BITS-1:0], 1'b0};
            n_quot = {r_quot[esr_pkg::QUOT_BITS-2:0], q_bit};
            n_cnt  = r_cnt - CNT_W'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem  <= n_rem;
        r_quot <= n_quot;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quot     = r_quot;

endmodule

FILE: design/esr_sqrt.sv
// Digit-by-digit integer square root, one result bit per cycle.
module esr_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  esr_pkg::t_unit_ctl            i_ctl,
    input  logic [esr_pkg::QUOT_BITS-1:0] i_frac,
    output esr_pkg::t_unit_sts            o_sts,
    output logic [esr_pkg::ROOT_BITS-1:0] o_root
);

    localparam int VW = esr_pkg::SQRT_VAL_W;

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [VW-1:0] r_val, n_val;
    logic [VW-1:0] r_res, n_res;
    logic [VW-1:0] r_bit, n_bit;
    logic [VW-1:0] trial;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_val  = r_val;
        n_res  = r_res;
        n_bit  = r_bit;
        trial  = r_res + r_bit;
        if (i_ctl.start) begin
            n_busy = 1'b1;
            n_val  = VW'({i_frac, esr_pkg::FRAC_BITS'(0)});
            n_res  = '0;
            n_bit  = VW'(1) << (VW - 2);
        end else if (r_busy) begin
            if (r_val >= trial) begin
                n_val = r_val - trial;
                n_res = (r_res >> 1) + r_bit;
            end else begin
                n_res = r_res >> 1;
            end
            n_bit = r_bit >> 2;
            if (r_bit[0]) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_val <= n_val;
        r_res <= n_res;
        r_bit <= n_bit;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_root     = r_res[esr_pkg::ROOT_BITS-1:0];

endmodule

FILE: design/envelope_stage_sqrt_ramp.sv
// Top level of the square-root ramp envelope segment generator.
// One envelope segment, driven by request transactions: start loads the
// initial level and runs, tick advances elapsed time by one microsecond and
// returns the new level, stop halts and returns the last level. Each accepted
// transaction returns exactly one result transaction. A tick that needs the
// curve goes in order through a range check of elapsed time, the
// bit-serial divider (elapsed/length as Q1.16) and the hand-over of the
// quotient, the bit-serial square root, the root*span multiply, the clamp
// and the load of the output register; the divider and root steps take
// the most time. Start, stop, ticks while stopped and ignored request codes
// go straight to the result; ticks on zero-length or finished segments pass
// through the range check first.
// One transaction is in flight at a time; the next is accepted as soon as the
// result sits in the output register, even while that result is stalled.
// Configuration writes are always ready and must be issued only while idle.
module envelope_stage_sqrt_ramp #(
    parameter int LEVEL_BITS  = 12,
    parameter int LENGTH_BITS = 24
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // request channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [1:0]                            i_req_type,
    input  logic [LEVEL_BITS-1:0]                 i_initial_level,
    // result channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [LEVEL_BITS-1:0]                 o_level,
    output logic                                  o_stage_done,
    // configuration write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [esr_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [((LENGTH_BITS > LEVEL_BITS) ? LENGTH_BITS : LEVEL_BITS)-1:0] i_cfg_data
);

    localparam int EL_W   = LENGTH_BITS + 1;
    localparam int PROD_W = esr_pkg::ROOT_BITS + LEVEL_BITS;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_EVAL   = 6'b000010,
        ST_DIV    = 6'b000100,
        ST_SQRT   = 6'b001000,
        ST_SCALE  = 6'b010000,
        ST_RESULT = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic [LENGTH_BITS-1:0] r_length;
    logic [LEVEL_BITS-1:0]  r_cfg_start;
    logic [LEVEL_BITS-1:0]  r_cfg_end;

    // segment state
    logic [EL_W-1:0]        r_elapsed, n_elapsed;
    logic [LEVEL_BITS-1:0]  r_active, n_active;
    logic [LEVEL_BITS-1:0]  r_last, n_last;
    logic                   r_running, n_running;

    // working and result registers
    logic [LEVEL_BITS-1:0]  r_span, n_span;
    logic [PROD_W-1:0]      r_prod, n_prod;
    logic [LEVEL_BITS-1:0]  r_res_level, n_res_level;
    logic                   r_res_done, n_res_done;
    logic                   r_out_valid, n_out_valid;
    logic [LEVEL_BITS-1:0]  r_out_level, n_out_level;
    logic                   r_out_done, n_out_done;

    logic                   in_accept;
    logic                   cfg_write;
    logic                   past_end;
    logic [LEVEL_BITS-1:0]  scaled;
    logic [LEVEL_BITS-1:0]  lim_up;
    logic [LEVEL_BITS-1:0]  lim_down;
    logic [LEVEL_BITS:0]    sum_up;
    logic [LEVEL_BITS-1:0]  ramp_level;

    esr_pkg::t_unit_ctl            div_ctl, sqrt_ctl;
    esr_pkg::t_unit_sts            div_sts, sqrt_sts;
    logic [esr_pkg::QUOT_BITS-1:0] frac;
    logic [esr_pkg::ROOT_BITS-1:0] root;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign past_end    = (r_elapsed > {1'b0, r_length});

    // Divider starts once the tick is known to be inside the segment.
    assign div_ctl.start  = (r_state == ST_EVAL) && (r_length != '0) && !past_end;
    assign sqrt_ctl.start = (r_state == ST_DIV) && div_sts.done;

    // Elapsed <= length on this path, so its top bit is zero.
    esr_div #(
        .NUM_BITS (LENGTH_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl),
        .i_dividend (r_elapsed[LENGTH_BITS-1:0]),
        .i_divisor  (r_length),
        .o_sts      (div_sts),
        .o_quot     (frac)
    );

    esr_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (sqrt_ctl),
        .i_frac  (frac),
        .o_sts   (sqrt_sts),
        .o_root  (root)
    );

    // root <= 1.0, so scaled never exceeds span and fits a level.
    always_comb begin
        scaled     = r_prod[esr_pkg::FRAC_BITS +: LEVEL_BITS];
        lim_up     = (scaled < r_cfg_end) ? scaled : r_cfg_end;
        sum_up     = {1'b0, lim_up} + {1'b0, r_active};
        lim_down   = (scaled < r_active) ? scaled : r_active;
        if (r_cfg_end > r_active) begin
            ramp_level = sum_up[LEVEL_BITS] ? '1 : sum_up[LEVEL_BITS-1:0];
        end else begin
            ramp_level = r_active - lim_down;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_elapsed   = r_elapsed;
        n_active    = r_active;
        n_last      = r_last;
        n_running   = r_running;
        n_span      = r_span;
        n_prod      = r_prod;
        n_res_level = r_res_level;
        n_res_done  = r_res_done;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_level = r_out_level;
        n_out_done  = r_out_done;

        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_res_level = r_last;
                    n_res_done  = 1'b0;
                    n_state     = ST_RESULT;
                    case (i_req_type)
                        esr_pkg::REQ_START: begin
                            n_active    = i_initial_level;
                            n_elapsed   = '0;
                            n_running   = 1'b1;
                            n_res_level = i_initial_level;
                        end
                        esr_pkg::REQ_TICK: begin
                            if (r_running) begin
                                if (r_elapsed != '1) begin
                                    n_elapsed = r_elapsed + EL_W'(1);
                                end
                                n_state = ST_EVAL;
                            end
                        end
                        esr_pkg::REQ_STOP: begin
                            n_running = 1'b0;
                            n_elapsed = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_EVAL: begin
                n_span = (r_cfg_end > r_cfg_start) ? (r_cfg_end - r_cfg_start)
                                                   : (r_cfg_start - r_cfg_end);
                if (r_length == '0) begin
                    n_res_level = r_active;
                    n_last      = r_active;
                    n_state     = ST_RESULT;
                end else if (past_end) begin
                    n_res_level = r_cfg_end;
                    n_res_done  = 1'b1;
                    n_last      = r_cfg_end;
                    n_state     = ST_RESULT;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_sts.done) begin
                    n_state = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (sqrt_sts.done) begin
                    n_prod  = PROD_W'(root) * PROD_W'(r_span);
                    n_state = ST_SCALE;
                end
            end
            ST_SCALE: begin
                n_res_level = ramp_level;
                n_last      = ramp_level;
                n_state     = ST_RESULT;
            end
            ST_RESULT: begin
                // Output register frees up when empty or being taken.
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_level = r_res_level;
                    n_out_done  = r_res_done;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_elapsed   <= '0;
            r_active    <= '0;
            r_last      <= '0;
            r_running   <= 1'b0;
            r_out_valid <= 1'b0;
            r_length    <= LENGTH_BITS'(1000);
            r_cfg_start <= '0;
            r_cfg_end   <= '1;
        end else begin
            r_state     <= n_state;
            r_elapsed   <= n_elapsed;
            r_active    <= n_active;
            r_last      <= n_last;
            r_running   <= n_running;
            r_out_valid <= n_out_valid;
            if (cfg_write) begin
                case (i_cfg_index)
                    esr_pkg::CFG_LENGTH: r_length    <= i_cfg_data[LENGTH_BITS-1:0];
                    esr_pkg::CFG_START:  r_cfg_start <= i_cfg_data[LEVEL_BITS-1:0];
                    esr_pkg::CFG_END:    r_cfg_end   <= i_cfg_data[LEVEL_BITS-1:0];
                    default: begin
                    end
                endcase
            end
        end
        r_span      <= n_span;
        r_prod      <= n_prod;
        r_res_level <= n_res_level;
        r_res_done  <= n_res_done;
        r_out_level <= n_out_level;
        r_out_done  <= n_out_done;
    end

    assign o_out_valid  = r_out_valid;
    assign o_level      = r_out_level;
    assign o_stage_done = r_out_done;

    // Serial units report completion only in the state waiting on them.
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_sts.done |-> (r_state == ST_DIV))
        else $error("divider finished outside its wait state");

    a_sqrt_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sqrt_sts.done |-> (r_state == ST_SQRT))
        else $error("square root finished outside its wait state");

    a_units_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!div_sts.busy && !sqrt_sts.busy))
        else $error("serial unit busy while idle");

    a_no_div_by_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_length != '0))
        else $error("division started with zero length");

    a_tick_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (i_req_type == esr_pkg::REQ_TICK) && r_running)
        |=> (r_elapsed != '0))
        else $error("running tick did not advance elapsed time");

endmodule

FILE: tb/envelope_stage_sqrt_ramp_test.sv
// Self-checking testbench for the square-root ramp envelope segment generator.
module envelope_stage_sqrt_ramp_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LVL_W = 12;
    localparam int LEN_W = 24;
    localparam int CFG_W = (LEN_W > LVL_W) ? LEN_W : LVL_W;

    // Request code 3 and register index 3 are not decoded; the block ignores them.
    localparam logic [1:0]                    REQ_RSVD = 2'd3;
    localparam logic [esr_pkg::CFG_IDX_W-1:0] CFG_RSVD = 2'd3;

    localparam logic [LVL_W-1:0] LVL_TOP     = '1;
    localparam logic [LEN_W:0]   ELAPSED_TOP = '1;

    localparam int     RAND_PHASES  = 8;
    localparam int     PHASE_ITEMS  = 50;
    localparam int     DRAIN_CYCLES = 60;   // idle margin after the last phase
    localparam int     HOLD_CYCLES  = 300;  // long result back-pressure
    localparam longint CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic [1:0]       kind;
        logic [LVL_W-1:0] lvl;
    } t_env_req;

    typedef struct packed {
        logic [LVL_W-1:0] level;
        logic             done;
    } t_env_level;

    // ------------------------------------------------------------------
    // DUT inputs, all known from time zero
    // ------------------------------------------------------------------
    logic                          i_clk           = 1'b0;
    logic                          i_rst_n         = 1'b0;
    logic                          i_in_valid      = 1'b0;
    logic                          o_in_stall;
    logic [1:0]                    i_req_type      = '0;
    logic [LVL_W-1:0]              i_initial_level = '0;
    logic                          o_out_valid;
    logic                          i_out_stall     = 1'b0;
    logic [LVL_W-1:0]              o_level;
    logic                          o_stage_done;
    logic                          i_cfg_valid     = 1'b0;
    logic                          o_cfg_ready;
    logic [esr_pkg::CFG_IDX_W-1:0] i_cfg_index     = '0;
    logic [CFG_W-1:0]              i_cfg_data      = '0;

    envelope_stage_sqrt_ramp #(
        .LEVEL_BITS  (LVL_W),
        .LENGTH_BITS (LEN_W)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_req_type      (i_req_type),
        .i_initial_level (i_initial_level),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_level         (o_level),
        .o_stage_done    (o_stage_done),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Envelope predictor state: a shadow of the registers and the segment
    // ------------------------------------------------------------------
    logic [LEN_W-1:0] cfg_len_us;
    logic [LVL_W-1:0] cfg_start_lvl;
    logic [LVL_W-1:0] cfg_end_lvl;
    logic [LEN_W:0]   env_elapsed;
    logic [LVL_W-1:0] env_origin;
    logic [LVL_W-1:0] env_last;
    logic             env_running;

    t_env_req   req_backlog[$];   // requests waiting for the driver
    t_env_level owed_levels[$];   // predicted results, oldest first

    int     offered_cnt = 0;      // requests put on the bus by the driver
    int     taken_cnt   = 0;      // request transactions accepted by the block
    int     fault_count = 0;
    longint cycle_count = 0;
    int     send_gap    = 0;
    int     recv_wait   = 0;
    logic   steady      = 1'b0;   // no random gaps on either side while set
    logic   squeeze     = 1'b0;   // kicks off the long result hold
    logic   long_hold   = 1'b0;

    // Bit-by-bit floor square root, result at most 2^16 here.
    function automatic bit [63:0] floor_root(input bit [63:0] v);
        bit [63:0] r;
        bit [63:0] t;
        r = '0;
        for (int b = 16; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= v)
                r = t;
        end
        return r;
    endfunction

    function automatic void apply_reg(input logic [esr_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [CFG_W-1:0] data);
        case (idx)
            esr_pkg::CFG_LENGTH: cfg_len_us    = data[LEN_W-1:0];
            esr_pkg::CFG_START:  cfg_start_lvl = data[LVL_W-1:0];
            esr_pkg::CFG_END:    cfg_end_lvl   = data[LVL_W-1:0];
            default: ;
        endcase
    endfunction

    // Moves the shadow segment by one request and returns the level it owes.
    function automatic t_env_level advance_envelope(input t_env_req rq);
        t_env_level r;
        bit [63:0]  span;
        bit [63:0]  frac;
        bit [63:0]  root;
        bit [63:0]  scaled;
        bit [63:0]  sum;
        r.level = env_last;
        r.done  = 1'b0;
        case (rq.kind)
            esr_pkg::REQ_START: begin
                // last level is left alone on a start
                env_origin  = rq.lvl;
                env_elapsed = '0;
                env_running = 1'b1;
                r.level     = rq.lvl;
            end
            esr_pkg::REQ_TICK: if (env_running) begin
                if (env_elapsed != ELAPSED_TOP)
                    env_elapsed++;
                if (cfg_len_us == '0) begin
                    r.level = env_origin;
                end else if (env_elapsed > cfg_len_us) begin
                    r.level = cfg_end_lvl;
                    r.done  = 1'b1;
                end else begin
                    span = (cfg_end_lvl > cfg_start_lvl) ? cfg_end_lvl - cfg_start_lvl
                                                         : cfg_start_lvl - cfg_end_lvl;
                    // Q1.16 fraction, Q1.16 root, both truncated
                    frac   = (64'(env_elapsed) << 16) / 64'(cfg_len_us);
                    root   = floor_root(frac << 16);
                    scaled = (root * span) >> 16;
                    if (cfg_end_lvl > env_origin) begin
                        sum = ((scaled < 64'(cfg_end_lvl)) ? scaled : 64'(cfg_end_lvl))
                              + 64'(env_origin);
                        r.level = (sum > 64'(LVL_TOP)) ? LVL_TOP : sum[LVL_W-1:0];
                    end else begin
                        r.level = env_origin - ((scaled < 64'(env_origin)) ?
                                                scaled[LVL_W-1:0] : env_origin);
                    end
                end
                env_last = r.level;
            end
            esr_pkg::REQ_STOP: begin
                env_running = 1'b0;
                env_elapsed = '0;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("ERROR %0t: %s got %0d, expected %0d", $time, what, got, want);
        fault_count++;
    endtask

    // ------------------------------------------------------------------
    // Bus watcher: register writes and accepted requests feed the predictor
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_len_us    = 24'd1000;
            cfg_start_lvl = '0;
            cfg_end_lvl   = LVL_TOP;
            env_elapsed   = '0;
            env_origin    = '0;
            env_last      = '0;
            env_running   = 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready)
                apply_reg(i_cfg_index, i_cfg_data);
            if (i_in_valid && !o_in_stall) begin
                owed_levels.push_back(advance_envelope('{kind: i_req_type,
                                                        lvl:  i_initial_level}));
                taken_cnt++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Request driver: pops the backlog, random gap after each transaction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_env_req nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap = 0;
        end else if (!(i_in_valid && o_in_stall)) begin
            // either idle or the current transaction was taken at this edge
            if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (req_backlog.size() != 0) begin
                nxt = req_backlog.pop_front();
                offered_cnt++;
                i_req_type      <= nxt.kind;
                i_initial_level <= nxt.lvl;
                i_in_valid      <= 1'b1;
                send_gap = steady ? 0 : $urandom_range(0, 8);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: random stall per result, plus the long hold
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            recv_wait = 0;
        end else begin
            if (o_out_valid && !i_out_stall)
                recv_wait = steady ? 0 : $urandom_range(0, 8);
            else if (o_out_valid && recv_wait > 0)
                recv_wait--;
            i_out_stall <= (recv_wait != 0) || long_hold;
        end
    end

    // Long back-pressure: the sender keeps going, so the block fills and
    // has to stall its request side.
    initial begin
        wait (squeeze);
        @(posedge i_clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        long_hold <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_env_level want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (owed_levels.size() == 0) begin
                report_mismatch("unexpected result, level", o_level, 0);
            end else begin
                want = owed_levels.pop_front();
                if (o_level !== want.level)
                    report_mismatch("level", o_level, want.level);
                if (o_stage_done !== want.done)
                    report_mismatch("stage_done", o_stage_done, want.done);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void queue_req(input logic [1:0] k, input logic [LVL_W-1:0] v);
        req_backlog.push_back('{kind: k, lvl: v});
    endfunction

    function automatic logic [LVL_W-1:0] pick_level();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return LVL_TOP;
            default: return LVL_W'($urandom);
        endcase
    endfunction

    // Register writes go out one transaction at a time, only while idle.
    task automatic write_reg(input logic [esr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Idle: nothing queued, nothing on the bus, no result outstanding.
    task automatic settle();
        while (req_backlog.size() != 0 || offered_cnt != taken_cnt ||
               owed_levels.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic random_config(output logic [LEN_W-1:0] len);
        case ($urandom_range(0, 9))
            0:       len = '0;
            1:       len = '1;
            2:       len = LEN_W'($urandom);
            default: len = LEN_W'($urandom_range(1, 30));
        endcase
        write_reg(esr_pkg::CFG_LENGTH, CFG_W'(len));
        write_reg(esr_pkg::CFG_START, CFG_W'(pick_level()));
        write_reg(esr_pkg::CFG_END, CFG_W'(pick_level()));
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_RSVD, CFG_W'($urandom));
    endtask

    // Mostly whole segments (start, a run of ticks, sometimes a stop), with
    // short segments run past their end. Now and then a burst of noise:
    // stray stop, tick while stopped, reserved request code.
    task automatic queue_random_run(input logic [LEN_W-1:0] len, input int n);
        int made;
        int ticks;
        int cap;
        made = 0;
        cap  = (len <= 40) ? int'(len) + 3 : 8;
        while (made < n) begin
            if ($urandom_range(0, 7) == 0) begin
                queue_req(esr_pkg::REQ_STOP, LVL_W'($urandom));
                queue_req(esr_pkg::REQ_TICK, LVL_W'($urandom));
                queue_req(REQ_RSVD, LVL_W'($urandom));
                made += 3;
            end else begin
                ticks = $urandom_range(1, cap);
                queue_req(esr_pkg::REQ_START, pick_level());
                repeat (ticks) queue_req(esr_pkg::REQ_TICK, LVL_W'($urandom));
                made += ticks + 1;
                if ($urandom_range(0, 1) == 1) begin
                    queue_req(esr_pkg::REQ_STOP, LVL_W'($urandom));
                    made++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        logic [LEN_W-1:0] len;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings (length 1000, span 0..4095): rising from zero,
        // stop, tick while stopped, reserved code, then falling from the top.
        queue_req(esr_pkg::REQ_START, '0);
        queue_req(esr_pkg::REQ_TICK, '0);
        queue_req(esr_pkg::REQ_TICK, LVL_TOP);
        queue_req(esr_pkg::REQ_STOP, '0);
        queue_req(esr_pkg::REQ_TICK, '0);
        queue_req(REQ_RSVD, LVL_TOP);
        queue_req(esr_pkg::REQ_START, LVL_TOP);
        queue_req(esr_pkg::REQ_TICK, '0);
        settle();

        // Short rising segment from near the top: sum saturates, then the
        // segment runs out and flags done.
        write_reg(esr_pkg::CFG_LENGTH, CFG_W'(4));
        write_reg(esr_pkg::CFG_START, '0);
        write_reg(esr_pkg::CFG_END, CFG_W'(LVL_TOP));
        queue_req(esr_pkg::REQ_START, 12'd4000);
        repeat (6) queue_req(esr_pkg::REQ_TICK, '0);
        settle();

        // Zero length holds the start level; level data above 12 bits is
        // dropped; index 3 must not disturb anything.
        write_reg(esr_pkg::CFG_LENGTH, '0);
        write_reg(esr_pkg::CFG_START, '1);
        write_reg(esr_pkg::CFG_END, '0);
        write_reg(CFG_RSVD, 24'h5A5A5A);
        queue_req(esr_pkg::REQ_START, 12'd1234);
        queue_req(esr_pkg::REQ_TICK, '0);
        queue_req(esr_pkg::REQ_TICK, '0);
        settle();

        // Longest segment, falling from the top.
        write_reg(esr_pkg::CFG_LENGTH, '1);
        queue_req(esr_pkg::REQ_START, LVL_TOP);
        queue_req(esr_pkg::REQ_TICK, '0);
        queue_req(esr_pkg::REQ_TICK, '0);
        queue_req(esr_pkg::REQ_STOP, '0);
        settle();
        // Elapsed-time saturation needs 2^25 - 1 ticks and stays out of reach.

        for (int p = 0; p < RAND_PHASES; p++) begin
            steady = (p % 4 == 1) || (p == 3);
            random_config(len);
            if (p == 3)
                squeeze = 1'b1;
            queue_random_run(len, PHASE_ITEMS);
            settle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fault_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
